// ===== hw/rtl/ladlp_pkg.sv =====
// Package for the four-pole ladder lowpass: widths, register codes, reset values,
// sequencer states and the fixed-point helpers (rounding, saturation).
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package ladlp_pkg;

   localparam int SAMPLE_WIDTH   = 24;
   localparam int COEF_FRAC_BITS = 30;
   localparam int FB_FRAC_BITS   = COEF_FRAC_BITS - 2;

   localparam int SIG_W      = 32;
   localparam int COEF_W     = 32;
   localparam int GAIN_W     = 31;
   localparam int PROD_W     = SIG_W + COEF_W;
   // A rounded product plus a few of them summed.
   localparam int WIDE_W     = PROD_W - FB_FRAC_BITS + 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int STAGE_W    = 2;

   localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(2);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_ONE    = 3'd0,
      CSR_GAIN_TWO    = 3'd1,
      CSR_GAIN_THREE  = 3'd2,
      CSR_GAIN_FOUR   = 3'd3,
      CSR_ALLPASS     = 3'd4,
      CSR_FEEDBACK    = 3'd5,
      CSR_INV_DENOM   = 3'd6
   } csr_index_type;

   localparam logic [GAIN_W-1:0]        GAIN_ONE_RST   = 31'd66046000;
   localparam logic [GAIN_W-1:0]        GAIN_TWO_RST   = 31'd4063000;
   localparam logic [GAIN_W-1:0]        GAIN_THREE_RST = 31'd249900;
   localparam logic [GAIN_W-1:0]        GAIN_FOUR_RST  = 31'd15370;
   localparam logic signed [COEF_W-1:0] ALLPASS_RST    = -32'sd941650000;
   localparam logic [GAIN_W-1:0]        FEEDBACK_RST   = 31'd0;
   localparam logic [GAIN_W-1:0]        INV_DENOM_RST  = 31'd1073741824;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_D0,
      ST_MUL_D1,
      ST_MUL_D2,
      ST_MUL_IN,
      ST_SUM_IN,
      ST_MUL_INV,
      ST_TAKE_OUT,
      ST_MUL_FB,
      ST_MUL_AP_OUT,
      ST_MUL_U,
      ST_TAKE_U,
      ST_STG_W,
      ST_STG_MUL_A,
      ST_STG_MUL_G,
      ST_STG_NEXT,
      ST_FINISH
   } state_type;

   localparam logic signed [PROD_W-1:0] ONE_P     = 1;
   localparam logic signed [PROD_W-1:0] COEF_HALF = ONE_P <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] FB_HALF   = ONE_P <<< (FB_FRAC_BITS - 1);

   localparam logic signed [WIDE_W-1:0] ONE_W     = 1;
   localparam logic signed [WIDE_W-1:0] SIG_MAX_W = (ONE_W <<< (SIG_W - 1)) - ONE_W;
   localparam logic signed [WIDE_W-1:0] SIG_MIN_W = -(ONE_W <<< (SIG_W - 1));

   localparam logic signed [SIG_W-1:0] ONE_S     = 1;
   localparam logic signed [SIG_W-1:0] SMP_MAX_S = (ONE_S <<< (SAMPLE_WIDTH - 1)) - ONE_S;
   localparam logic signed [SIG_W-1:0] SMP_MIN_S = -(ONE_S <<< (SAMPLE_WIDTH - 1));

   // Add half an LSB, then floor: the arithmetic shift floors for both signs.
   function automatic logic signed [WIDE_W-1:0] round_product(
      input logic signed [PROD_W-1:0] p,
      input logic                     use_fb
   );
      logic signed [PROD_W-1:0] shifted;
      if (use_fb) begin
         shifted = (p + FB_HALF) >>> FB_FRAC_BITS;
      end else begin
         shifted = (p + COEF_HALF) >>> COEF_FRAC_BITS;
      end
      return shifted[WIDE_W-1:0];
   endfunction

   function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [WIDE_W-1:0] x);
      if (x > SIG_MAX_W) begin
         return SIG_MAX_W[SIG_W-1:0];
      end else if (x < SIG_MIN_W) begin
         return SIG_MIN_W[SIG_W-1:0];
      end
      return x[SIG_W-1:0];
   endfunction

   function automatic logic signed [WIDE_W-1:0] widen(input logic signed [SIG_W-1:0] x);
      return WIDE_W'(x);
   endfunction

   function automatic logic signed [SIG_W-1:0] ext_sample(
      input logic signed [SAMPLE_WIDTH-1:0] s
   );
      return SIG_W'(s);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
      input logic signed [SIG_W-1:0] x
   );
      if (x > SMP_MAX_S) begin
         return SMP_MAX_S[SAMPLE_WIDTH-1:0];
      end else if (x < SMP_MIN_S) begin
         return SMP_MIN_S[SAMPLE_WIDTH-1:0];
      end
      return x[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

// ===== hw/rtl/ladlp_if.sv =====
// Channel interfaces of the ladder lowpass: sample requests, filtered results
// and register writes, each with valid and ready. Depends on ladlp_pkg.
`timescale 1ns / 1ps

interface ladlp_req_if;
   import ladlp_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   logic                           clear_state;
   modport source (output valid, sample_in, clear_state, input ready);
   modport sink   (input valid, sample_in, clear_state, output ready);
endinterface

interface ladlp_rsp_if;
   import ladlp_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

interface ladlp_csr_if;
   import ladlp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/four_pole_ladder_lowpass_core.sv =====
// Top level of the resonant four-pole zero-delay-feedback ladder lowpass.
// Depends on ladlp_pkg and the channel interfaces in ladlp_if.sv.
//
//   channel | direction | payload                     | accepted when
//   req_if  | in        | sample_in, clear_state      | valid & ready
//   rsp_if  | out       | sample_out                  | valid & ready
//   csr_if  | in        | index, data (register write)| valid & ready (ready held high)
//
// An item passes from acceptance to the next acceptance through eleven
// sequencer steps for the ladder output and feedback, four for each of the three
// one-pole stages, one to finish and the idle state. One 32x32 multiplier with a
// registered product serves every product, so the dependent products set the
// pace. Reset is synchronous and clears the delays and loads the register
// defaults. A finished item waits in the output register; a new item is taken
// meanwhile, and only the last step stalls while that register is still full.
`timescale 1ns / 1ps

module four_pole_ladder_lowpass_core (
   input logic        clock,
   input logic        reset,
   ladlp_req_if.sink  req_if,
   ladlp_rsp_if.source rsp_if,
   ladlp_csr_if.sink  csr_if
);
   import ladlp_pkg::*;

   state_type state_ff, state_in;

   logic [GAIN_W-1:0]        gain_one_ff, gain_two_ff, gain_three_ff, gain_four_ff;
   logic signed [COEF_W-1:0] allpass_ff;
   logic [GAIN_W-1:0]        feedback_ff, inv_denom_ff;

   logic signed [SIG_W-1:0]        delay_ff [4];
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic [STAGE_W-1:0]             stage_ff;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic                           fb_sel_ff, fb_sel_in;
   logic signed [WIDE_W-1:0]       acc_ff;
   logic signed [WIDE_W-1:0]       ap_term_ff;
   logic signed [SIG_W-1:0]        out_ff, u_ff, w_ff;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff;

   logic signed [SIG_W-1:0]  op_a;
   logic signed [COEF_W-1:0] op_b;
   logic signed [WIDE_W-1:0] rnd;
   logic                     accept;
   logic                     out_free;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign rnd      = round_product(prod_ff, fb_sel_ff);

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign csr_if.ready      = 1'b1;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_data_ff;

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_if.valid) state_in = ST_MUL_D0;
         ST_MUL_D0:     state_in = ST_MUL_D1;
         ST_MUL_D1:     state_in = ST_MUL_D2;
         ST_MUL_D2:     state_in = ST_MUL_IN;
         ST_MUL_IN:     state_in = ST_SUM_IN;
         ST_SUM_IN:     state_in = ST_MUL_INV;
         ST_MUL_INV:    state_in = ST_TAKE_OUT;
         ST_TAKE_OUT:   state_in = ST_MUL_FB;
         ST_MUL_FB:     state_in = ST_MUL_AP_OUT;
         ST_MUL_AP_OUT: state_in = ST_MUL_U;
         ST_MUL_U:      state_in = ST_TAKE_U;
         ST_TAKE_U:     state_in = ST_STG_W;
         ST_STG_W:      state_in = ST_STG_MUL_A;
         ST_STG_MUL_A:  state_in = ST_STG_MUL_G;
         ST_STG_MUL_G:  state_in = ST_STG_NEXT;
         ST_STG_NEXT:   state_in = (stage_ff == LAST_STAGE) ? ST_FINISH : ST_STG_W;
         ST_FINISH:     if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: multiplier operands and the rounding shift select.
   always_comb begin
      op_a      = '0;
      op_b      = '0;
      fb_sel_in = 1'b0;
      case (state_ff)
         ST_MUL_D0: begin
            op_a = delay_ff[0];
            op_b = $signed(COEF_W'(gain_three_ff));
         end
         ST_MUL_D1: begin
            op_a = delay_ff[1];
            op_b = $signed(COEF_W'(gain_two_ff));
         end
         ST_MUL_D2: begin
            op_a = delay_ff[2];
            op_b = $signed(COEF_W'(gain_one_ff));
         end
         ST_MUL_IN: begin
            op_a = ext_sample(sample_ff);
            op_b = $signed(COEF_W'(gain_four_ff));
         end
         ST_MUL_INV: begin
            op_a = acc_ff[SIG_W-1:0];
            op_b = $signed(COEF_W'(inv_denom_ff));
         end
         ST_MUL_FB: begin
            op_a      = out_ff;
            op_b      = $signed(COEF_W'(feedback_ff));
            fb_sel_in = 1'b1;
         end
         ST_MUL_AP_OUT: begin
            op_a = out_ff;
            op_b = allpass_ff;
         end
         ST_MUL_U: begin
            op_a = u_ff;
            op_b = $signed(COEF_W'(gain_one_ff));
         end
         ST_STG_MUL_A: begin
            op_a = w_ff;
            op_b = allpass_ff;
         end
         ST_STG_MUL_G: begin
            op_a = w_ff;
            op_b = $signed(COEF_W'(gain_one_ff));
         end
         default: begin
            op_a      = '0;
            op_b      = '0;
            fb_sel_in = 1'b0;
         end
      endcase
   end

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      fb_sel_ff <= fb_sel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            delay_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sample_ff <= req_if.sample_in;
                  stage_ff  <= '0;
                  if (req_if.clear_state) begin
                     for (int i = 0; i < 4; i++) begin
                        delay_ff[i] <= '0;
                     end
                  end
               end
            end
            ST_MUL_D1:   acc_ff <= widen(delay_ff[3]) + rnd;
            ST_MUL_D2:   acc_ff <= acc_ff + rnd;
            ST_MUL_IN:   acc_ff <= widen(sat_sig(acc_ff + rnd));
            ST_SUM_IN:   acc_ff <= widen(sat_sig(acc_ff + rnd));
            ST_TAKE_OUT: out_ff <= sat_sig(rnd);
            // Input less the saturated resonance feedback.
            ST_MUL_AP_OUT: begin
               u_ff <= sat_sig(widen(ext_sample(sample_ff)) - widen(sat_sig(rnd)));
            end
            ST_MUL_U:    ap_term_ff <= rnd;
            ST_TAKE_U:   u_ff <= sat_sig(rnd);
            ST_STG_W:    w_ff <= sat_sig(widen(delay_ff[stage_ff]) + widen(u_ff));
            ST_STG_MUL_G: delay_ff[stage_ff] <= sat_sig(widen(u_ff) - rnd);
            ST_STG_NEXT: begin
               u_ff     <= sat_sig(rnd);
               stage_ff <= stage_ff + STAGE_W'(1);
            end
            ST_FINISH: begin
               if (out_free) begin
                  delay_ff[3] <= sat_sig(widen(u_ff) - ap_term_ff);
                  rsp_data_ff <= sat_sample(out_ff);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Register writes; the port is always ready and unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_one_ff   <= GAIN_ONE_RST;
         gain_two_ff   <= GAIN_TWO_RST;
         gain_three_ff <= GAIN_THREE_RST;
         gain_four_ff  <= GAIN_FOUR_RST;
         allpass_ff    <= ALLPASS_RST;
         feedback_ff   <= FEEDBACK_RST;
         inv_denom_ff  <= INV_DENOM_RST;
      end else if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_GAIN_ONE:   gain_one_ff   <= csr_if.data[GAIN_W-1:0];
            CSR_GAIN_TWO:   gain_two_ff   <= csr_if.data[GAIN_W-1:0];
            CSR_GAIN_THREE: gain_three_ff <= csr_if.data[GAIN_W-1:0];
            CSR_GAIN_FOUR:  gain_four_ff  <= csr_if.data[GAIN_W-1:0];
            CSR_ALLPASS:    allpass_ff    <= $signed(csr_if.data[COEF_W-1:0]);
            CSR_FEEDBACK:   feedback_ff   <= csr_if.data[GAIN_W-1:0];
            CSR_INV_DENOM:  inv_denom_ff  <= csr_if.data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MUL_D0) && !req_if.ready)
      else $error("accepted item did not start the sequencer");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.clear_state) |=>
         (delay_ff[0] == '0) && (delay_ff[1] == '0) &&
         (delay_ff[2] == '0) && (delay_ff[3] == '0))
      else $error("clear flag did not zero the stage delays");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_if.valid && req_if.ready)
      else $error("finished item not presented or block not ready again");

   a_csr_gain_one: assert property (@(posedge clock) disable iff (reset)
      (csr_if.valid && csr_if.index == CSR_GAIN_ONE) |=>
         gain_one_ff == $past(csr_if.data[GAIN_W-1:0]))
      else $error("gain register write lost");
`endif

endmodule

// ===== tb/sv/tb_four_pole_ladder_lowpass_core.sv =====
// Self-checking testbench for the four-pole ladder lowpass core: directed and random samples,
// several coefficient settings and handshake stalls, checked against a bit-exact predictor.
// Depends on ladlp_pkg, the channel interfaces in ladlp_if.sv and the core itself.
`timescale 1ns / 1ps

module tb_four_pole_ladder_lowpass_core;
   import ladlp_pkg::*;

   localparam int TIMEOUT_NS   = 4_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 110;
   localparam int DIR_ROWS     = 25;
   localparam int END_CYCLES   = 60;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = 24'sh800000;

   localparam longint SIG_MAX_L = 64'sd2147483647;
   localparam longint SIG_MIN_L = -64'sd2147483648;
   localparam longint SMP_MAX_L = 64'sd8388607;
   localparam longint SMP_MIN_L = -64'sd8388608;

   typedef struct packed {
      logic [1:0]                     setting;
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           clear;
      logic                           known;
      logic signed [SAMPLE_WIDTH-1:0] known_out;
   } directed_row_type;

   // Setting 0 is the reset state, 1 every register all ones but the allpass at its most
   // negative value, 2 every register zero, 3 a bright resonant filter with a positive allpass.
   directed_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{2'd0, 24'sd0,       1'b0, 1'b1, 24'sd0},
      '{2'd0, S_MAX,        1'b0, 1'b0, 24'sd0},
      '{2'd0, S_MAX,        1'b0, 1'b0, 24'sd0},
      '{2'd0, S_MIN,        1'b0, 1'b0, 24'sd0},
      '{2'd0, 24'sd1,       1'b0, 1'b0, 24'sd0},
      '{2'd0, -24'sd1,      1'b0, 1'b0, 24'sd0},
      '{2'd0, S_MIN,        1'b0, 1'b0, 24'sd0},
      '{2'd0, 24'sd0,       1'b1, 1'b1, 24'sd0},
      '{2'd0, S_MAX,        1'b1, 1'b0, 24'sd0},
      '{2'd0, 24'sh555555,  1'b0, 1'b0, 24'sd0},
      '{2'd0, 24'shAAAAAA,  1'b0, 1'b0, 24'sd0},
      '{2'd2, S_MAX,        1'b0, 1'b1, 24'sd0},
      '{2'd2, S_MIN,        1'b1, 1'b1, 24'sd0},
      '{2'd2, 24'sh123456,  1'b0, 1'b1, 24'sd0},
      '{2'd1, S_MAX,        1'b1, 1'b1, S_MAX},
      '{2'd1, S_MIN,        1'b1, 1'b1, S_MIN},
      '{2'd1, S_MAX,        1'b0, 1'b0, 24'sd0},
      '{2'd1, S_MIN,        1'b0, 1'b0, 24'sd0},
      '{2'd1, 24'sd0,       1'b0, 1'b0, 24'sd0},
      '{2'd1, 24'sd0,       1'b1, 1'b1, 24'sd0},
      '{2'd3, S_MAX,        1'b1, 1'b0, 24'sd0},
      '{2'd3, 24'sd0,       1'b0, 1'b0, 24'sd0},
      '{2'd3, S_MIN,        1'b0, 1'b0, 24'sd0},
      '{2'd3, 24'sd0,       1'b0, 1'b0, 24'sd0},
      '{2'd3, 24'sh000100,  1'b1, 1'b0, 24'sd0}
   };

   logic clock = 1'b0;
   logic reset;

   ladlp_req_if req_bus ();
   ladlp_rsp_if rsp_bus ();
   ladlp_csr_if csr_bus ();

   four_pole_ladder_lowpass_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor copy of the coefficients and the four stage delays.
   longint coef_g1, coef_g2, coef_g3, coef_g4, coef_a, coef_k, coef_inv;
   longint delay_line [0:3];

   logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
   logic [CSR_DATA_W-1:0]          reg_words [0:6];

   int error_count     = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int settings_loaded = 0;
   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int hold_requests   = 0;
   int holds_served    = 0;
   int hold_left       = 0;

   function automatic longint clamp32(input longint x);
      if (x > SIG_MAX_L) begin
         return SIG_MAX_L;
      end else if (x < SIG_MIN_L) begin
         return SIG_MIN_L;
      end
      return x;
   endfunction

   // Product rounded half up back to signal scale.
   function automatic longint round_mul(input longint x, input longint c, input int frac);
      longint p;
      p = x * c + (longint'(1) <<< (frac - 1));
      return p >>> frac;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] filter_sample(
      input logic signed [SAMPLE_WIDTH-1:0] s_in,
      input logic                           clr
   );
      longint s, acc, o, u, w, y;
      s = longint'(s_in);
      if (clr) begin
         for (int j = 0; j < 4; j++) delay_line[j] = 0;
      end
      acc = delay_line[3] + round_mul(delay_line[0], coef_g3, COEF_FRAC_BITS)
          + round_mul(delay_line[1], coef_g2, COEF_FRAC_BITS)
          + round_mul(delay_line[2], coef_g1, COEF_FRAC_BITS);
      acc = clamp32(acc);
      acc = clamp32(round_mul(s, coef_g4, COEF_FRAC_BITS) + acc);
      o = clamp32(round_mul(acc, coef_inv, COEF_FRAC_BITS));

      // Feedback-corrected input through the three allpass-form stages.
      u = clamp32(s - clamp32(round_mul(o, coef_k, FB_FRAC_BITS)));
      u = clamp32(round_mul(u, coef_g1, COEF_FRAC_BITS));
      for (int j = 0; j < 3; j++) begin
         w = clamp32(delay_line[j] + u);
         delay_line[j] = clamp32(u - round_mul(w, coef_a, COEF_FRAC_BITS));
         u = clamp32(round_mul(w, coef_g1, COEF_FRAC_BITS));
      end
      delay_line[3] = clamp32(u - round_mul(o, coef_a, COEF_FRAC_BITS));

      y = o;
      if (y > SMP_MAX_L) y = SMP_MAX_L;
      if (y < SMP_MIN_L) y = SMP_MIN_L;
      return SAMPLE_WIDTH'(y);
   endfunction

   function automatic void store_coefficient(
      input logic [CSR_IDX_W-1:0]  idx,
      input logic [CSR_DATA_W-1:0] value
   );
      case (idx)
         CSR_GAIN_ONE:   coef_g1  = longint'(value[GAIN_W-1:0]);
         CSR_GAIN_TWO:   coef_g2  = longint'(value[GAIN_W-1:0]);
         CSR_GAIN_THREE: coef_g3  = longint'(value[GAIN_W-1:0]);
         CSR_GAIN_FOUR:  coef_g4  = longint'(value[GAIN_W-1:0]);
         CSR_ALLPASS:    coef_a   = longint'(signed'(value));
         CSR_FEEDBACK:   coef_k   = longint'(value[GAIN_W-1:0]);
         CSR_INV_DENOM:  coef_inv = longint'(value[GAIN_W-1:0]);
         default: ;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] to_fixed(input real x, input real scale);
      return CSR_DATA_W'($rtoi(x * scale));
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      store_coefficient(idx, value);
   endtask

   // Writes the seven coefficient words, then a word to the unused index.
   task automatic load_registers();
      write_reg(CSR_GAIN_ONE,   reg_words[CSR_GAIN_ONE]);
      write_reg(CSR_GAIN_TWO,   reg_words[CSR_GAIN_TWO]);
      write_reg(CSR_GAIN_THREE, reg_words[CSR_GAIN_THREE]);
      write_reg(CSR_GAIN_FOUR,  reg_words[CSR_GAIN_FOUR]);
      write_reg(CSR_ALLPASS,    reg_words[CSR_ALLPASS]);
      write_reg(CSR_FEEDBACK,   reg_words[CSR_FEEDBACK]);
      write_reg(CSR_INV_DENOM,  reg_words[CSR_INV_DENOM]);
      write_reg(CSR_UNUSED_IDX, $urandom);
      csr_bus.valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic pick_preset(input int which);
      case (which)
         0: reg_words = '{32'(GAIN_ONE_RST), 32'(GAIN_TWO_RST), 32'(GAIN_THREE_RST),
                          32'(GAIN_FOUR_RST), ALLPASS_RST, 32'(FEEDBACK_RST),
                          32'(INV_DENOM_RST)};
         1: reg_words = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                          32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF};
         2: reg_words = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
         default: reg_words = '{32'd715827883, 32'd477218588, 32'd318145725,
                                32'd212097150, 32'h40000000, 32'd1073741824,
                                32'd599813000};
      endcase
   endtask

   // Coefficients of a plausible filter: random cutoff word w and resonance.
   task automatic build_musical();
      real w, g, k, inv;
      w = $urandom_range(1, 3000) / 1000.0;
      g = w / (1.0 + w);
      k = $urandom_range(0, 4000) / 1000.0;
      inv = 1.0 / (1.0 + k * g * g * g * g);
      reg_words[CSR_GAIN_ONE]   = to_fixed(g, 1073741824.0);
      reg_words[CSR_GAIN_TWO]   = to_fixed(g * g, 1073741824.0);
      reg_words[CSR_GAIN_THREE] = to_fixed(g * g * g, 1073741824.0);
      reg_words[CSR_GAIN_FOUR]  = to_fixed(g * g * g * g, 1073741824.0);
      reg_words[CSR_ALLPASS]    = to_fixed((w - 1.0) / (w + 1.0), 1073741824.0);
      reg_words[CSR_FEEDBACK]   = to_fixed(k, 268435456.0);
      reg_words[CSR_INV_DENOM]  = to_fixed(inv, 1073741824.0);
   endtask

   task automatic send_sample(
      input logic signed [SAMPLE_WIDTH-1:0] s_in,
      input logic                           clr,
      input logic                           known,
      input logic signed [SAMPLE_WIDTH-1:0] known_out
   );
      int gap;
      logic signed [SAMPLE_WIDTH-1:0] predicted;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample_in   <= s_in;
      req_bus.clear_state <= clr;
      do @(posedge clock); while (!req_bus.ready);
      predicted = filter_sample(s_in, clr);
      expected_samples.push_back(known ? known_out : predicted);
      items_sent++;
   endtask

   // Stops offering items and waits for every outstanding result.
   task automatic wait_until_quiet();
      req_bus.valid <= 1'b0;
      while (results_checked != items_sent) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin sender_idle_pct = 46; recv_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  recv_stall_pct = 46; end
         default: begin sender_idle_pct = 29; recv_stall_pct = 29; end
      endcase
   endtask

   // Result side: checks each accepted item, then chooses the next ready.
   always @(posedge clock) begin
      logic signed [SAMPLE_WIDTH-1:0] exp_out;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: result with no sample outstanding, expected none, got %0d",
                     $time, rsp_bus.sample_out);
            error_count++;
         end else begin
            exp_out = expected_samples.pop_front();
            if (rsp_bus.sample_out !== exp_out) begin
               $display("%0t: sample_out mismatch, expected %0d, got %0d",
                        $time, exp_out, rsp_bus.sample_out);
               error_count++;
            end
         end
         results_checked <= results_checked + 1;
      end
      if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout after %0d items sent and %0d results checked", items_sent,
               results_checked);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int current_setting;
      int kind;
      logic signed [SAMPLE_WIDTH-1:0] s_val;
      logic signed [SAMPLE_WIDTH-1:0] ramp;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.sample_in   = '0;
      req_bus.clear_state = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;
      rsp_bus.ready       = 1'b0;

      pick_preset(0);
      for (int i = 0; i < 7; i++) store_coefficient(CSR_IDX_W'(i), reg_words[i]);
      for (int j = 0; j < 4; j++) delay_line[j] = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part; the reset coefficients stand until a row asks for another setting.
      current_setting = 0;
      set_idling(0);
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (int'(dir_rows[r].setting) != current_setting) begin
            wait_until_quiet();
            pick_preset(dir_rows[r].setting);
            load_registers();
            current_setting = dir_rows[r].setting;
         end
         send_sample(dir_rows[r].sample, dir_rows[r].clear, dir_rows[r].known,
                     dir_rows[r].known_out);
      end

      ramp = '0;
      for (int p = 0; p < PHASES; p++) begin
         wait_until_quiet();
         set_idling(p % 4);
         case (p)
            1, 4:    begin for (int i = 0; i < 7; i++) reg_words[i] = $urandom; end
            6:       pick_preset(3);
            default: build_musical();
         endcase
         load_registers();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Long output hold-off early in the first phase, with the sender still busy.
            if (p == 0 && n == 20) hold_requests <= hold_requests + 1;
            kind = $urandom_range(99);
            if (kind < 50) begin
               s_val = SAMPLE_WIDTH'($urandom);
            end else if (kind < 80) begin
               s_val = SAMPLE_WIDTH'($signed($urandom_range(0, 131072)) - 65536);
            end else if (kind < 90) begin
               s_val = $urandom_range(1) ? S_MAX : S_MIN;
            end else begin
               ramp  = ramp + 24'sd40000;
               s_val = ramp;
            end
            send_sample(s_val, $urandom_range(39) == 0, 1'b0, '0);
         end
      end

      wait_until_quiet();
      repeat (END_CYCLES) @(posedge clock);

      $display("Filtered %0d samples under %0d register settings, %0d results checked.",
               items_sent, settings_loaded, results_checked);
      $display("Covered extremes, state clears, idle and stall phases and a long hold-off.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== four_pole_ladder_lowpass_core.f =====
hw/rtl/ladlp_pkg.sv
hw/rtl/ladlp_if.sv
hw/rtl/four_pole_ladder_lowpass_core.sv
tb/sv/tb_four_pole_ladder_lowpass_core.sv
